>>> hdl/hexmix_pkg.sv
// ----------------------------------------------------------------------------
// hexmix_pkg
// Shared types, constants and arithmetic helpers for the X-hexacopter motor
// mixer: field widths, register indexes, launch timing and Q10 rounding.
// ----------------------------------------------------------------------------
`default_nettype none

package hexmix_pkg;

    // Field widths
    localparam int ThrW   = 12;     // throttle and threshold registers
    localparam int TermW  = 12;     // roll / pitch / yaw terms
    localparam int AccW   = 16;     // vertical acceleration sample
    localparam int OneGW  = 14;     // accel_one_g register
    localparam int CmdW   = 14;     // motor command on the output
    localparam int MixW   = 15;     // mixed command before limiting
    localparam int SumW   = 25;     // Q10 accumulator
    localparam int LimW   = 17;     // headroom for shift and clamp
    localparam int NumMot = 6;

    localparam int InDataW  = 80;   // 78 bits of fields, padded to bytes
    localparam int OutDataW = 88;   // 85 bits of fields, padded to bytes

    // Q10 weights
    localparam logic signed [SumW-1:0] HalfQ10  = 25'sd512;
    localparam logic signed [SumW-1:0] Cos30Q10 = 25'sd887;
    localparam logic signed [SumW-1:0] Q10Mask  = 25'sd1023;

    // Fixed commands and launch timing
    localparam logic [CmdW-1:0] IdleCmd    = 14'd1000;
    localparam logic [ThrW-1:0] LaunchBase = 12'd1800;
    localparam logic [ThrW-1:0] LaunchLen  = 12'd3000;
    localparam logic [ThrW-1:0] RampStart  = 12'd1000;
    localparam logic [ThrW-1:0] StepTicks  = 12'd500;
    localparam logic [ThrW-1:0] StepDrop   = 12'd30;

    // Register reset values
    localparam logic [ThrW-1:0]  MinThrRst   = 12'd1100;
    localparam logic [ThrW-1:0]  MaxThrRst   = 12'd1900;
    localparam logic [ThrW-1:0]  StickMinRst = 12'd1100;
    localparam logic [OneGW-1:0] OneGRst     = 14'd4096;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIN_THR   = 2'd0,
        CFG_MAX_THR   = 2'd1,
        CFG_STICK_MIN = 2'd2,
        CFG_ONE_G     = 2'd3
    } t_cfg_reg;

    typedef logic signed [MixW-1:0] t_mix;

    // Launch controller to limiter
    typedef struct packed {
        logic            active;
        logic [ThrW-1:0] throttle;
    } t_launch_ctl;

    // Q10 to integer, truncating toward zero
    function automatic t_mix q10_trunc(input logic signed [SumW-1:0] num);
        logic signed [SumW-1:0] adj;
        adj = num + (num[SumW-1] ? Q10Mask : '0);
        return adj[SumW-1:10];
    endfunction

endpackage

`default_nettype wire

>>> hdl/hexmix_mixer.sv
// ----------------------------------------------------------------------------
// hexmix_mixer
// X-hexacopter mix of one throttle and the roll, pitch and yaw terms into six
// motor commands, formed exactly in Q10 and truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hexmix_mixer
    import hexmix_pkg::*;
(
    input  wire logic        [ThrW-1:0]  i_throttle,
    input  wire logic signed [TermW-1:0] i_roll,
    input  wire logic signed [TermW-1:0] i_pitch,
    input  wire logic signed [TermW-1:0] i_yaw,
    output t_mix                         o_mot [NumMot]
);

    logic signed [SumW-1:0] tq, rh, pc, rq, yq;

    // Scaled terms
    always_comb begin
        tq = $signed({{(SumW-ThrW-10){1'b0}}, i_throttle, 10'b0});
        rh = SumW'(i_roll) * HalfQ10;
        pc = SumW'(i_pitch) * Cos30Q10;
        rq = {{(SumW-TermW-10){i_roll[TermW-1]}}, i_roll, 10'b0};
        yq = {{(SumW-TermW-10){i_yaw[TermW-1]}}, i_yaw, 10'b0};
    end

    // Per-motor sums: RL, FR, RR, FL, L, R
    always_comb begin
        o_mot[0] = q10_trunc(tq + rh + pc - yq);
        o_mot[1] = q10_trunc(tq - rh - pc + yq);
        o_mot[2] = q10_trunc(tq - rh + pc + yq);
        o_mot[3] = q10_trunc(tq + rh - pc - yq);
        o_mot[4] = q10_trunc(tq + rq + yq);
        o_mot[5] = q10_trunc(tq - rq - yq);
    end

endmodule

`default_nettype wire

>>> hdl/hexmix_launch.sv
// ----------------------------------------------------------------------------
// hexmix_launch
// Launch sequencer: tick counter, done flag, trigger decision and the
// stepped launch throttle for the current transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module hexmix_launch
    import hexmix_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_step,
    input  wire logic                    i_armed,
    input  wire logic signed [AccW-1:0]  i_accel_z,
    input  wire logic        [OneGW-1:0] i_accel_one_g,
    output t_launch_ctl                  o_ctl
);

    localparam logic [ThrW-1:0] Edge1 = RampStart + StepTicks;
    localparam logic [ThrW-1:0] Edge2 = ThrW'(RampStart + 2 * StepTicks);
    localparam logic [ThrW-1:0] Edge3 = ThrW'(RampStart + 3 * StepTicks);

    logic [ThrW-1:0] r_ticks, n_ticks;
    logic            r_done, n_done;
    logic            spike, run;
    logic [ThrW-1:0] tick_inc;

    // Spike: accel_z above twice one g
    assign spike = $signed({i_accel_z[AccW-1], i_accel_z})
                 > $signed({2'b00, i_accel_one_g, 1'b0});
    assign run   = i_armed && (spike || !r_done) && (r_ticks < LaunchLen);
    assign tick_inc = r_ticks + 1'b1;

    // Launch throttle steps down by StepDrop at RampStart plus one, two and three StepTicks, then holds
    always_comb begin
        o_ctl.active = run;
        if (r_ticks >= Edge3) begin
            o_ctl.throttle = LaunchBase - ThrW'(3 * StepDrop);
        end else if (r_ticks >= Edge2) begin
            o_ctl.throttle = LaunchBase - ThrW'(2 * StepDrop);
        end else if (r_ticks >= Edge1) begin
            o_ctl.throttle = LaunchBase - StepDrop;
        end else begin
            o_ctl.throttle = LaunchBase;
        end
    end

    // Next state
    always_comb begin
        n_ticks = r_ticks;
        n_done  = r_done;
        if (i_step && run) begin
            if (tick_inc == LaunchLen) begin
                n_ticks = '0;
                n_done  = 1'b1;
            end else begin
                n_ticks = tick_inc;
                n_done  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= '0;
            r_done  <= 1'b0;
        end else begin
            r_ticks <= n_ticks;
            r_done  <= n_done;
        end
    end

    // Counter never sits at or past the launch length
    a_ticks_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ticks < LaunchLen)
        else $error("launch tick counter out of range");

    // A finished launch leaves the counter at zero
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_ticks == '0))
        else $error("launch done with nonzero tick count");

    // Counter only moves on a launch step
    a_ticks_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_step && run) |=> $stable(r_ticks))
        else $error("launch counter moved without a step");

endmodule

`default_nettype wire

>>> hdl/hexacopter_motor_mixer.sv
// ----------------------------------------------------------------------------
// hexacopter_motor_mixer
// X-hexacopter six-motor mixer with limit shift, clamp, idle override and
// timed launch mode.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Each input is captured in an
// input register, mixed, limited and launch-processed in a single pass, and
// lands in the output register when that register is empty or taken, and a
// new input is taken every cycle while the output side keeps up; a stalled
// output still lets one more input enter the input register. Launch state
// advances as each item leaves the input register, so items see it in
// arrival order.
// Configuration is a plain write port and is meant to change only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module hexacopter_motor_mixer
    import hexmix_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    // Config write port
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [OneGW-1:0]     i_cfg_data,

    // Input stream
    input  wire logic                 s_axis_tvalid,
    output      logic                 s_axis_tready,
    // base_throttle[11:0], roll_term[23:12], pitch_term[35:24],
    // yaw_term[47:36], armed[48], alt_hold[49], stick_throttle[61:50],
    // accel_z[77:62], zero pad[79:78]
    input  wire logic [InDataW-1:0]   s_axis_tdata,

    // Output stream
    output      logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // motor_rear_left[13:0], motor_front_right[27:14],
    // motor_rear_right[41:28], motor_front_left[55:42], motor_left[69:56],
    // motor_right[83:70], launch_active[84], zero pad[87:85]
    output      logic [OutDataW-1:0]  m_axis_tdata
);

    // Config registers
    logic [ThrW-1:0]  r_min_thr, r_max_thr, r_stick_min;
    logic [OneGW-1:0] r_one_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_thr   <= MinThrRst;
            r_max_thr   <= MaxThrRst;
            r_stick_min <= StickMinRst;
            r_one_g     <= OneGRst;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_MIN_THR:   r_min_thr   <= i_cfg_data[ThrW-1:0];
                CFG_MAX_THR:   r_max_thr   <= i_cfg_data[ThrW-1:0];
                CFG_STICK_MIN: r_stick_min <= i_cfg_data[ThrW-1:0];
                CFG_ONE_G:     r_one_g     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: output register advances when empty or taken
    logic r_s1_vld, r_out_vld;
    logic out_adv, s1_step;

    assign out_adv       = !r_out_vld || m_axis_tready;
    assign s1_step       = r_s1_vld && out_adv;
    assign s_axis_tready = !r_s1_vld || out_adv;
    assign m_axis_tvalid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_s1_vld <= s_axis_tvalid;
            end
            if (out_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    // Input register
    logic [InDataW-1:0] r_in;

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_axis_tdata;
        end
    end

    logic        [ThrW-1:0]  base_thr, stick_thr;
    logic signed [TermW-1:0] roll, pitch, yaw;
    logic                    armed, alt_hold;
    logic signed [AccW-1:0]  accel_z;

    assign base_thr  = r_in[11:0];
    assign roll      = r_in[23:12];
    assign pitch     = r_in[35:24];
    assign yaw       = r_in[47:36];
    assign armed     = r_in[48];
    assign alt_hold  = r_in[49];
    assign stick_thr = r_in[61:50];
    assign accel_z   = r_in[77:62];

    // Normal and launch mixes
    t_mix        mix_norm [NumMot];
    t_mix        mix_lnch [NumMot];
    t_launch_ctl lctl;

    hexmix_mixer u_mix_norm (
        .i_throttle (base_thr),
        .i_roll     (roll),
        .i_pitch    (pitch),
        .i_yaw      (yaw),
        .o_mot      (mix_norm)
    );

    hexmix_mixer u_mix_lnch (
        .i_throttle (lctl.throttle),
        .i_roll     (roll),
        .i_pitch    (pitch),
        .i_yaw      (yaw),
        .o_mot      (mix_lnch)
    );

    hexmix_launch u_launch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (s1_step),
        .i_armed       (armed),
        .i_accel_z     (accel_z),
        .i_accel_one_g (r_one_g),
        .o_ctl         (lctl)
    );

    // Largest command
    logic signed [MixW-1:0] mx01, mx23, mx45, mx03, mx;

    always_comb begin
        mx01 = (mix_norm[1] > mix_norm[0]) ? mix_norm[1] : mix_norm[0];
        mx23 = (mix_norm[3] > mix_norm[2]) ? mix_norm[3] : mix_norm[2];
        mx45 = (mix_norm[5] > mix_norm[4]) ? mix_norm[5] : mix_norm[4];
        mx03 = (mx23 > mx01) ? mx23 : mx01;
        mx   = (mx45 > mx03) ? mx45 : mx03;
    end

    // Shift down by the excess, clamp, then idle and launch overrides
    logic signed [LimW-1:0] lo, hi, mx_w, excess, sh;
    logic                   idle;
    logic [CmdW-1:0]        cmd [NumMot];

    assign lo     = $signed({{(LimW-ThrW){1'b0}}, r_min_thr});
    assign hi     = $signed({{(LimW-ThrW){1'b0}}, r_max_thr});
    assign mx_w   = LimW'(mx);
    assign excess = (mx_w > hi) ? (mx_w - hi) : '0;
    assign idle   = !armed || (!alt_hold && (stick_thr < r_stick_min));

    always_comb begin
        for (int i = 0; i < NumMot; i++) begin
            sh = LimW'(mix_norm[i]) - excess;
            if (sh < lo) begin
                sh = lo;
            end else if (sh > hi) begin
                sh = hi;
            end
            if (lctl.active) begin
                cmd[i] = mix_lnch[i][CmdW-1:0];
            end else if (idle) begin
                cmd[i] = IdleCmd;
            end else begin
                cmd[i] = sh[CmdW-1:0];
            end
        end
    end

    // Output register
    logic [OutDataW-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_out <= {3'b000, lctl.active, cmd[5], cmd[4], cmd[3],
                      cmd[2], cmd[1], cmd[0]};
        end
    end

    assign m_axis_tdata = r_out;

    // A valid result never carries nonzero padding bits
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out[OutDataW-1:85] == '0))
        else $error("output padding not zero");

    // With ordered limits, the first motor command of a non-launch, non-idle result lies within them
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_step && !lctl.active && !idle && (r_min_thr <= r_max_thr))
        |-> ($signed({3'b000, cmd[0]}) >= lo && $signed({3'b000, cmd[0]}) <= hi))
        else $error("clamped command outside limits");

    // A pending result that is not taken stays pending
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |=> (r_out_vld && $stable(r_out)))
        else $error("output register dropped a pending result");

endmodule

`default_nettype wire
